/* hw/rtl/itds_pkg.sv */
`default_nettype none

package itds_pkg;

    // Number of value bits taken from the input.
    localparam int VALUE_BITS = 32;
    localparam int MAX_DEC_DIGITS = 10;
    localparam int HEX_MAX_DIGITS = 8;
    // The largest position weight is 10**9, which fits in 30 bits.
    localparam int POW_W = 30;
    localparam int CNT_W = $clog2(VALUE_BITS);
    // Later positions have a quotient below 16, so four division steps do.
    localparam int DIGIT_BITS = 4;

    localparam logic [4:0] SYM_SPACE    = 5'd16;
    localparam logic [4:0] SYM_QUESTION = 5'd17;
    localparam logic [4:0] SYM_END      = 5'd18;

    localparam logic [1:0] ALIGN_RIGHT = 2'd1;
    localparam logic [1:0] ALIGN_ZEROS = 2'd2;

    typedef logic [1:0] upc_t;

    localparam upc_t UPC_IDLE = 2'd0;
    localparam upc_t UPC_DIV  = 2'd1;
    localparam upc_t UPC_EMIT = 2'd2;
    localparam upc_t UPC_TERM = 2'd3;

    typedef enum logic [1:0] {
        OP_IDLE,
        OP_DIV,
        OP_EMIT,
        OP_TERM
    } op_t;

    typedef enum logic [1:0] {
        C_NO_START,
        C_DIV_MORE,
        C_MORE_POS,
        C_ALWAYS
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } uword_t;

    typedef struct packed {
        logic div_more;
        logic more_pos;
    } dp_status_t;

    // Weight of the digit position with exponent e in the chosen radix.
    function automatic logic [POW_W-1:0] pow_of(input logic hex, input logic [3:0] e);
        logic [POW_W-1:0] p;
        p = POW_W'(1);
        if (hex)
        begin
            p = POW_W'(1) << {e[2:0], 2'b00};
        end
        else
        begin
            unique case (e)
                4'd0: p = POW_W'(1);
                4'd1: p = POW_W'(10);
                4'd2: p = POW_W'(100);
                4'd3: p = POW_W'(1000);
                4'd4: p = POW_W'(10000);
                4'd5: p = POW_W'(100000);
                4'd6: p = POW_W'(1000000);
                4'd7: p = POW_W'(10000000);
                4'd8: p = POW_W'(100000000);
                4'd9: p = POW_W'(1000000000);
                default: p = POW_W'(1);
            endcase
        end
        return p;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/itds_rom.sv */
`default_nettype none

module itds_rom (
    input  wire itds_pkg::upc_t   addr,
    output itds_pkg::uword_t      word
);

    always_comb
    begin
        unique case (addr)
            itds_pkg::UPC_IDLE:
                word = '{op: itds_pkg::OP_IDLE, cond: itds_pkg::C_NO_START,
                         target: itds_pkg::UPC_IDLE};
            itds_pkg::UPC_DIV:
                word = '{op: itds_pkg::OP_DIV, cond: itds_pkg::C_DIV_MORE,
                         target: itds_pkg::UPC_DIV};
            itds_pkg::UPC_EMIT:
                word = '{op: itds_pkg::OP_EMIT, cond: itds_pkg::C_MORE_POS,
                         target: itds_pkg::UPC_DIV};
            itds_pkg::UPC_TERM:
                word = '{op: itds_pkg::OP_TERM, cond: itds_pkg::C_ALWAYS,
                         target: itds_pkg::UPC_IDLE};
            default:
                word = '{op: itds_pkg::OP_IDLE, cond: itds_pkg::C_ALWAYS,
                         target: itds_pkg::UPC_IDLE};
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/itds_seq.sv */
`default_nettype none

module itds_seq (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  wire itds_pkg::dp_status_t status,
    output itds_pkg::op_t            op,
    output logic                     busy
);

    itds_pkg::upc_t   pc_reg;
    itds_pkg::upc_t   pc_next;
    itds_pkg::uword_t word;
    logic             take;

    itds_rom u_rom (
        .addr (pc_reg),
        .word (word)
    );

    always_comb
    begin
        unique case (word.cond)
            itds_pkg::C_NO_START: take = !start;
            itds_pkg::C_DIV_MORE: take = status.div_more;
            itds_pkg::C_MORE_POS: take = status.more_pos;
            itds_pkg::C_ALWAYS:   take = 1'b1;
            default:              take = 1'b1;
        endcase
        pc_next = take ? word.target : itds_pkg::upc_t'(pc_reg + 2'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= itds_pkg::UPC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign op   = word.op;
    assign busy = (pc_reg != itds_pkg::UPC_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/itds_dp.sv */
`default_nettype none

module itds_dp (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire itds_pkg::op_t          op,
    input  wire                         start,
    input  wire                         kind,
    input  wire [31:0]                  value,
    input  wire [1:0]                   align_mode,
    input  wire [3:0]                   digit_count,
    output itds_pkg::dp_status_t        status,
    output logic                        strobe,
    output logic [4:0]                  symbol,
    output logic                        last
);

    localparam int POW_W = itds_pkg::POW_W;
    localparam int VB    = itds_pkg::VALUE_BITS;
    localparam int CNT_W = itds_pkg::CNT_W;

    logic                  hex_reg;
    logic                  writing_reg;
    logic                  spaces_reg;
    logic [3:0]            exp_reg;
    logic [POW_W-1:0]      rem_reg;
    logic [VB-1:0]         dvd_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [3:0]            quo_reg;
    logic                  ovf_reg;
    logic                  strobe_reg;
    logic [4:0]            symbol_reg;
    logic                  last_reg;

    logic [3:0]            n_clamp;
    logic [3:0]            n_max;
    logic [POW_W-1:0]      power;
    logic [POW_W:0]        shifted;
    logic                  fits;
    logic [POW_W:0]        diff;
    logic                  q_nonzero;
    logic                  q_bad;
    logic                  emit_digit;

    always_comb
    begin
        n_max   = kind ? 4'(itds_pkg::HEX_MAX_DIGITS) : 4'(itds_pkg::MAX_DEC_DIGITS);
        n_clamp = digit_count;
        if (digit_count == 4'd0)
        begin
            n_clamp = 4'd1;
        end
        else if (digit_count > n_max)
        begin
            n_clamp = n_max;
        end

        power   = itds_pkg::pow_of(hex_reg, exp_reg);
        // One restoring division step: bring down the next dividend bit.
        shifted = {rem_reg, dvd_reg[VB-1]};
        fits    = (shifted >= {1'b0, power});
        diff    = shifted - {1'b0, power};

        q_nonzero  = ovf_reg || (quo_reg != 4'd0);
        q_bad      = ovf_reg || (!hex_reg && (quo_reg > 4'd9));
        emit_digit = writing_reg || q_nonzero || (exp_reg == 4'd0);
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            itds_pkg::OP_IDLE:
            begin
                if (start)
                begin
                    hex_reg     <= kind;
                    writing_reg <= (align_mode == itds_pkg::ALIGN_ZEROS);
                    spaces_reg  <= (align_mode == itds_pkg::ALIGN_RIGHT);
                    exp_reg     <= n_clamp - 4'd1;
                    rem_reg     <= '0;
                    dvd_reg     <= value[VB-1:0];
                    cnt_reg     <= CNT_W'(VB - 1);
                    quo_reg     <= 4'd0;
                    ovf_reg     <= 1'b0;
                end
            end
            itds_pkg::OP_DIV:
            begin
                rem_reg <= fits ? diff[POW_W-1:0] : shifted[POW_W-1:0];
                dvd_reg <= {dvd_reg[VB-2:0], 1'b0};
                quo_reg <= {quo_reg[2:0], fits};
                ovf_reg <= ovf_reg | quo_reg[3];
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            itds_pkg::OP_EMIT:
            begin
                if (emit_digit)
                begin
                    writing_reg <= 1'b1;
                end
                if (exp_reg != 4'd0)
                begin
                    // The remainder is below this weight, so the next quotient
                    // fits in four bits: preload all but its low four bits.
                    exp_reg <= exp_reg - 4'd1;
                    rem_reg <= rem_reg >> itds_pkg::DIGIT_BITS;
                    dvd_reg <= {rem_reg[itds_pkg::DIGIT_BITS-1:0],
                                (VB - itds_pkg::DIGIT_BITS)'(0)};
                    cnt_reg <= CNT_W'(itds_pkg::DIGIT_BITS - 1);
                    quo_reg <= 4'd0;
                    ovf_reg <= 1'b0;
                end
            end
            itds_pkg::OP_TERM:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ((op == itds_pkg::OP_EMIT) && (emit_digit || spaces_reg))
                          || (op == itds_pkg::OP_TERM);
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= (op == itds_pkg::OP_TERM);
        if (op == itds_pkg::OP_TERM)
        begin
            symbol_reg <= itds_pkg::SYM_END;
        end
        else if (emit_digit)
        begin
            symbol_reg <= q_bad ? itds_pkg::SYM_QUESTION : {1'b0, quo_reg};
        end
        else
        begin
            symbol_reg <= itds_pkg::SYM_SPACE;
        end
    end

    assign status.div_more = (cnt_reg != '0);
    assign status.more_pos = (exp_reg != 4'd0);
    assign strobe = strobe_reg;
    assign symbol = symbol_reg;
    assign last   = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/integer_to_digit_string_top.sv */
// The bit-serial divider finds the leading position in 32 steps and each later one in 4;
// each position that is shown yields its symbol, and the terminator follows the last one.
// A new item is taken only while the block is idle, so not before the previous item's
// terminator step has been run.
// Reset is asynchronous and active low; it returns the step counter to idle and
// clears the result strobe. Results cannot be stalled by the receiver.
`default_nettype none

module integer_to_digit_string_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         kind,
    input  wire [31:0]  value,
    input  wire [1:0]   align_mode,
    input  wire [3:0]   digit_count,
    output logic        strobe,
    output logic [4:0]  symbol,
    output logic        last
);

    itds_pkg::op_t        op;
    itds_pkg::dp_status_t status;

    itds_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .op     (op),
        .busy   (busy)
    );

    itds_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .start       (start),
        .kind        (kind),
        .value       (value),
        .align_mode  (align_mode),
        .digit_count (digit_count),
        .status      (status),
        .strobe      (strobe),
        .symbol      (symbol),
        .last        (last)
    );

endmodule

`default_nettype wire

/* hw/rtl/itds_checker.sv */
`default_nettype none

module itds_checker (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    input  wire        busy,
    input  wire        strobe,
    input  wire [4:0]  symbol,
    input  wire        last
);

    // An accepted item always occupies the block for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item transfer did not raise busy");

    // The end of a run is the terminator and nothing else is.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (last == (symbol == itds_pkg::SYM_END)))
        else $error("terminator and last disagree");

    // Going idle coincides with the terminator transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && last)
        else $error("block went idle without a terminator");

    // No result follows the terminator directly.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("result right after the terminator");

    // Symbols stay within the defined code range.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> symbol <= itds_pkg::SYM_END)
        else $error("symbol code out of range");

endmodule

bind integer_to_digit_string_top itds_checker u_itds_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam logic       KIND_DEC    = 1'b0;
    localparam logic       KIND_HEX    = 1'b1;
    localparam logic [1:0] ALIGN_LEFT  = 2'd0;
    // Mode three is not defined and falls back to left align.
    localparam logic [1:0] ALIGN_SPARE = 2'd3;

    localparam int RANDOM_ITEMS   = 76;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int TAIL_CYCLES    = 100;

    typedef struct packed {
        logic             kind;
        logic [31:0]      value;
        logic [1:0]       align;
        logic [3:0]       count;
        logic [3:0]       n_typed;
        logic [0:9][4:0]  typed;
    } number_request_t;

    typedef struct packed {
        logic [4:0] sym;
        logic       is_last;
    } digit_symbol_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        kind = 1'b0;
    logic [31:0] value = 32'd0;
    logic [1:0]  align_mode = 2'd0;
    logic [3:0]  digit_count = 4'd1;
    logic        busy;
    logic        strobe;
    logic [4:0]  symbol;
    logic        last;

    digit_symbol_t   expected_symbols[$];
    number_request_t directed_rows[$];
    bit              quiet = 1'b0;
    int              mismatch_count = 0;
    int              numbers_sent = 0;
    int              hex_numbers = 0;
    int              symbols_checked = 0;
    int              question_marks = 0;
    int              spaces_seen = 0;
    int              idle_cycles = 0;

    integer_to_digit_string_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .value       (value),
        .align_mode  (align_mode),
        .digit_count (digit_count),
        .strobe      (strobe),
        .symbol      (symbol),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void expect_symbol(input logic [4:0] sym, input logic is_last);
        digit_symbol_t entry;
        entry.sym = sym;
        entry.is_last = is_last;
        expected_symbols.push_back(entry);
    endfunction

    // Walks the positions from the heaviest weight down, dividing out each digit.
    function automatic void predict_digit_string(input logic hex, input logic [31:0] number,
                                                 input logic [1:0] align,
                                                 input logic [3:0] count);
        logic [63:0] rest;
        logic [63:0] weight;
        logic [63:0] quot;
        logic [63:0] radix;
        int          positions;
        int          top_positions;
        int          i;
        bit          writing;
        bit          padding;
        rest = 64'(number);
        radix = hex ? 64'd16 : 64'd10;
        top_positions = hex ? itds_pkg::HEX_MAX_DIGITS : itds_pkg::MAX_DEC_DIGITS;
        positions = (count == 4'd0) ? 1 : int'(count);
        if (positions > top_positions)
        begin
            positions = top_positions;
        end
        weight = 64'd1;
        for (i = 1; i < positions; i++)
        begin
            weight = weight * radix;
        end
        writing = (align == itds_pkg::ALIGN_ZEROS);
        padding = (align == itds_pkg::ALIGN_RIGHT);
        for (i = 0; i < positions; i++)
        begin
            quot = rest / weight;
            if (writing || quot != 64'd0 || weight == 64'd1)
            begin
                writing = 1'b1;
                expect_symbol((quot < radix) ? 5'(quot) : itds_pkg::SYM_QUESTION, 1'b0);
            end
            else if (padding)
            begin
                expect_symbol(itds_pkg::SYM_SPACE, 1'b0);
            end
            rest = rest % weight;
            weight = weight / radix;
            if (weight == 64'd0)
            begin
                weight = 64'd1;
            end
        end
        expect_symbol(itds_pkg::SYM_END, 1'b1);
    endfunction

    // The text spells the symbols before the terminator; an empty text leaves
    // the row to the predictor.
    function automatic number_request_t make_row(input logic k, input logic [31:0] v,
                                                 input logic [1:0] a, input logic [3:0] c,
                                                 input string text);
        number_request_t row;
        logic [7:0]      ch;
        int              i;
        row = '0;
        row.kind = k;
        row.value = v;
        row.align = a;
        row.count = c;
        row.n_typed = 4'(text.len());
        for (i = 0; i < text.len(); i++)
        begin
            ch = text[i];
            if (ch == " ")
                row.typed[i] = itds_pkg::SYM_SPACE;
            else if (ch == "?")
                row.typed[i] = itds_pkg::SYM_QUESTION;
            else if (ch >= "a")
                row.typed[i] = 5'(ch - "a" + 8'd10);
            else
                row.typed[i] = 5'(ch - "0");
        end
        return row;
    endfunction

    task automatic send_number(input number_request_t row);
        bit done;
        int i;
        done = 1'b0;
        while (!done)
        begin
            if (!quiet && $urandom_range(0, 99) < 9)
            begin
                start <= 1'b0;
            end
            else
            begin
                start <= 1'b1;
                kind <= row.kind;
                value <= row.value;
                align_mode <= row.align;
                digit_count <= row.count;
            end
            @(posedge clk);
            if (start && !busy)
            begin
                done = 1'b1;
                numbers_sent++;
                if (row.kind == KIND_HEX)
                    hex_numbers++;
                if (row.n_typed == 4'd0)
                begin
                    predict_digit_string(row.kind, row.value, row.align, row.count);
                end
                else
                begin
                    for (i = 0; i < int'(row.n_typed); i++)
                    begin
                        expect_symbol(row.typed[i], 1'b0);
                    end
                    expect_symbol(itds_pkg::SYM_END, 1'b1);
                end
            end
        end
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        while (expected_symbols.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        digit_symbol_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (expected_symbols.size() == 0)
                begin
                    $display("%0t: unexpected symbol %0d, last %0b", $realtime, symbol, last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_symbols.pop_front();
                    symbols_checked++;
                    if (symbol == itds_pkg::SYM_QUESTION)
                        question_marks++;
                    if (symbol == itds_pkg::SYM_SPACE)
                        spaces_seen++;
                    if (symbol !== want.sym)
                    begin
                        $display("%0t: symbol expected %0d, got %0d",
                                 $realtime, want.sym, symbol);
                        mismatch_count++;
                    end
                    if (last !== want.is_last)
                    begin
                        $display("%0t: last expected %0b, got %0b",
                                 $realtime, want.is_last, last);
                        mismatch_count++;
                    end
                end
            end
            if ((start && !busy) || strobe)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $realtime, idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        number_request_t row;
        int              n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_rows.push_back(make_row(KIND_DEC, 32'd0, ALIGN_LEFT, 4'd1, "0"));
        directed_rows.push_back(make_row(KIND_DEC, 32'd0, ALIGN_LEFT, 4'd10, "0"));
        directed_rows.push_back(make_row(KIND_DEC, 32'd0, itds_pkg::ALIGN_RIGHT, 4'd4,
                                         "   0"));
        directed_rows.push_back(make_row(KIND_DEC, 32'd0, itds_pkg::ALIGN_ZEROS, 4'd3,
                                         "000"));
        directed_rows.push_back(make_row(KIND_DEC, 32'hFFFF_FFFF, itds_pkg::ALIGN_ZEROS,
                                         4'd10, "4294967295"));
        directed_rows.push_back(make_row(KIND_HEX, 32'hFFFF_FFFF, ALIGN_LEFT, 4'd8,
                                         "ffffffff"));
        directed_rows.push_back(make_row(KIND_HEX, 32'hDEAD_BEEF, itds_pkg::ALIGN_ZEROS,
                                         4'd8, "deadbeef"));
        directed_rows.push_back(make_row(KIND_DEC, 32'd123, ALIGN_LEFT, 4'd3, "123"));
        // The leading quotient does not fit one digit and shows as a question mark.
        directed_rows.push_back(make_row(KIND_DEC, 32'd5000, ALIGN_LEFT, 4'd3, "?00"));
        directed_rows.push_back(make_row(KIND_HEX, 32'h100, ALIGN_LEFT, 4'd2, "?0"));
        directed_rows.push_back(make_row(KIND_DEC, 32'd9, itds_pkg::ALIGN_RIGHT, 4'd1,
                                         "9"));
        directed_rows.push_back(make_row(KIND_HEX, 32'hA, itds_pkg::ALIGN_ZEROS, 4'd1,
                                         "a"));
        directed_rows.push_back(make_row(KIND_DEC, 32'd42, ALIGN_SPARE, 4'd5, ""));
        directed_rows.push_back(make_row(KIND_DEC, 32'd7, itds_pkg::ALIGN_ZEROS, 4'd0, ""));
        directed_rows.push_back(make_row(KIND_HEX, 32'd0, itds_pkg::ALIGN_RIGHT, 4'd0, ""));
        directed_rows.push_back(make_row(KIND_DEC, 32'hFFFF_FFFF, ALIGN_LEFT, 4'd15, ""));
        directed_rows.push_back(make_row(KIND_HEX, 32'h1234_5678, itds_pkg::ALIGN_ZEROS,
                                         4'd10, ""));
        directed_rows.push_back(make_row(KIND_HEX, 32'hF, itds_pkg::ALIGN_RIGHT, 4'd9, ""));
        directed_rows.push_back(make_row(KIND_DEC, 32'd1, itds_pkg::ALIGN_RIGHT, 4'd10, ""));
        directed_rows.push_back(make_row(KIND_DEC, 32'd1000000000, itds_pkg::ALIGN_ZEROS,
                                         4'd10, ""));
        directed_rows.push_back(make_row(KIND_HEX, 32'h8000_0000, itds_pkg::ALIGN_RIGHT,
                                         4'd8, ""));
        directed_rows.push_back(make_row(KIND_DEC, 32'h5555_5555, ALIGN_LEFT, 4'd5, ""));
        directed_rows.push_back(make_row(KIND_HEX, 32'hAAAA_AAAA, itds_pkg::ALIGN_RIGHT,
                                         4'd11, ""));
        directed_rows.push_back(make_row(KIND_DEC, 32'h7FFF_FFFF, ALIGN_SPARE, 4'd12, ""));

        foreach (directed_rows[r])
        begin
            send_number(directed_rows[r]);
        end
        wait_for_drain();

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // A stretch in the middle runs back to back with no sender gaps.
            quiet = (n >= 30 && n < 60);
            if (n == 70)
            begin
                wait_for_drain();
            end
            row = '0;
            row.kind = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: row.value = $urandom;
                1: row.value = $urandom >> $urandom_range(0, 31);
                2: row.value = $urandom_range(0, 99);
                default: row.value = $urandom >> $urandom_range(20, 31);
            endcase
            if ($urandom_range(0, 9) == 0)
            begin
                row.align = 2'($urandom_range(0, 3));
                row.count = 4'($urandom_range(0, 15));
            end
            else
            begin
                row.align = 2'($urandom_range(0, 2));
                row.count = row.kind ? 4'($urandom_range(1, 8)) : 4'($urandom_range(1, 10));
            end
            send_number(row);
        end
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d numbers (%0d hexadecimal) over all align modes and counts,",
                 numbers_sent, hex_numbers);
        $display("comparing %0d symbols, %0d question marks and %0d spaces among them.",
                 symbols_checked, question_marks, spaces_seen);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/itds_pkg.sv
hw/rtl/itds_rom.sv
hw/rtl/itds_seq.sv
hw/rtl/itds_dp.sv
hw/rtl/integer_to_digit_string_top.sv
hw/rtl/itds_checker.sv
dv/testbench.sv
